// ----- hdl/wnm_pkg.sv -----
// ----------------------------------------------------------------------------
// wnm_pkg
// Shared constants, types and the star closure for the wildcard name matcher.
// ----------------------------------------------------------------------------
package wnm_pkg;

  // mask geometry
  localparam int MASK_LEN_MAX = 32;
  localparam int POS_W        = MASK_LEN_MAX + 1;   // active position vector
  localparam int LEN_W        = 6;                  // mask_length register width
  localparam int CHARS_W      = MASK_LEN_MAX * 8;

  // special mask characters
  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CHARS_LOW      = 3'd0;
  localparam logic [2:0] REG_CHARS_MID_LOW  = 3'd1;
  localparam logic [2:0] REG_CHARS_MID_HIGH = 3'd2;
  localparam logic [2:0] REG_CHARS_HIGH     = 3'd3;
  localparam logic [2:0] REG_MASK_LENGTH    = 3'd4;

  // reset values
  localparam logic [63:0]      CHARS_LOW_RST = 64'd42;
  localparam logic [LEN_W-1:0] MASK_LEN_RST  = LEN_W'(1);
  localparam logic [POS_W-1:0] POS_START     = POS_W'(1);

  // mask as seen by the step logic
  typedef struct packed {
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
  } wnm_cfg_t;

  // step outcome
  typedef struct packed {
    logic [POS_W-1:0] next_act;
    logic             matched;
  } wnm_res_t;

  // star closure: an active position p whose mask byte is a star also
  // activates p+1, repeated along runs of stars; parallel prefix form
  function automatic logic [POS_W-1:0] star_closure(
    input logic [POS_W-1:0]        v,
    input logic [MASK_LEN_MAX-1:0] prop
  );
    logic [POS_W-1:0] g;
    logic [POS_W-1:0] pp;
    logic [POS_W-1:0] g_n;
    logic [POS_W-1:0] pp_n;
    int d;
    g  = v;
    pp = {prop, 1'b0};
    for (int lvl = 0; lvl < $clog2(POS_W); lvl++) begin
      d    = 1 << lvl;
      g_n  = g;
      pp_n = pp;
      for (int i = 0; i < POS_W; i++) begin
        if (i >= d) begin
          g_n[i]  = g[i] | (pp[i] & g[i-d]);
          pp_n[i] = pp[i] & pp[i-d];
        end
      end
      g  = g_n;
      pp = pp_n;
    end
    return g;
  endfunction

endpackage

// ----- hdl/wnm_step.sv -----
// ----------------------------------------------------------------------------
// wnm_step
// One name byte against the mask: next active positions and the verdict.
// ----------------------------------------------------------------------------
module wnm_step
  import wnm_pkg::*;
(
  input  wnm_cfg_t         cfg,
  input  logic [POS_W-1:0] act,
  input  logic [7:0]       name_byte,
  output wnm_res_t         res
);

  logic [LEN_W-1:0]        eff_len;
  logic [MASK_LEN_MAX-1:0] en;
  logic [MASK_LEN_MAX-1:0] is_star;
  logic [MASK_LEN_MAX-1:0] is_hit;
  logic [MASK_LEN_MAX-1:0] prop;
  logic [POS_W-1:0]        cur;
  logic [POS_W-1:0]        nxt;
  logic [POS_W-1:0]        fin;

  // length saturates at the mask size
  assign eff_len = (cfg.len > LEN_W'(MASK_LEN_MAX)) ? LEN_W'(MASK_LEN_MAX) : cfg.len;

  // per position classification of the mask bytes
  always_comb begin
    for (int p = 0; p < MASK_LEN_MAX; p++) begin
      en[p]      = LEN_W'(p) < eff_len;
      is_star[p] = cfg.chars[8*p +: 8] == STAR_CHAR;
      is_hit[p]  = (cfg.chars[8*p +: 8] == ANY_CHAR) || (cfg.chars[8*p +: 8] == name_byte);
    end
  end

  assign prop = is_star & en;
  assign cur  = star_closure(act, prop);

  // advance every active position by one name byte
  always_comb begin
    nxt = '0;
    for (int p = 0; p < MASK_LEN_MAX; p++) begin
      if (cur[p] && en[p]) begin
        if (is_star[p]) begin
          nxt[p] = 1'b1;
        end else if (is_hit[p]) begin
          nxt[p+1] = 1'b1;
        end
      end
    end
  end

  // trailing stars may take an empty remainder
  assign fin = star_closure(nxt, prop);

  assign res.next_act = nxt;
  assign res.matched  = fin[eff_len];

endmodule

// ----- hdl/wildcard_name_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// wildcard_name_matcher_unit
// Streams file names byte by byte against a '*' / '?' wildcard mask.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one name byte per transaction in in_tdata, with
//   in_tlast on the last byte of a name. For every last byte one transaction
//   leaves on the output stream, out_tdata[0] set when the whole name matches
//   the mask; other bytes give no output.
//   The mask (up to 32 bytes) and its length are written over the cfg_ APB
//   port, 64-bit registers at byte addresses 0, 8, 16, 24 and 32; write them
//   between names. Reset loads a single '*' mask, which matches every name.
//   Timing: an accepted byte is matched while it sits in the input register
//   and the verdict enters the output register, which drives out_tvalid.
//   One byte is taken every cycle unless a last byte is held for a busy
//   output, set by the combinational update of the active position
//   vector (star closure, byte compare, star closure).
//   When the receiver stalls, the output register holds the verdict; non-last
//   bytes keep flowing, and a further last byte waits in the input register,
//   then in_tready drops.
//   Reset is synchronous and active low; it empties both registers and
//   restarts the position vector.
// ----------------------------------------------------------------------------
module wildcard_name_matcher_unit
  import wnm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] name_byte
  input  logic        in_tlast,      // name_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // [0] matched, [7:1] zero
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0]      chars_r [4];
  logic [LEN_W-1:0] len_r;
  logic [POS_W-1:0] act_r;
  logic [POS_W-1:0] act_nxt;
  logic             in_vld_r;
  logic [7:0]       byte_r;
  logic             end_r;
  logic             out_vld_r;
  logic             matched_r;
  logic             out_free;
  logic             proc;
  logic             cfg_wr;
  logic [2:0]       reg_idx;
  wnm_cfg_t         step_cfg;
  wnm_res_t         step_res;

  // configuration port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r[0] <= CHARS_LOW_RST;
      chars_r[1] <= '0;
      chars_r[2] <= '0;
      chars_r[3] <= '0;
      len_r      <= MASK_LEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CHARS_LOW:      chars_r[0] <= cfg_pwdata;
        REG_CHARS_MID_LOW:  chars_r[1] <= cfg_pwdata;
        REG_CHARS_MID_HIGH: chars_r[2] <= cfg_pwdata;
        REG_CHARS_HIGH:     chars_r[3] <= cfg_pwdata;
        REG_MASK_LENGTH:    len_r      <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_CHARS_LOW:      cfg_prdata = chars_r[0];
      REG_CHARS_MID_LOW:  cfg_prdata = chars_r[1];
      REG_CHARS_MID_HIGH: cfg_prdata = chars_r[2];
      REG_CHARS_HIGH:     cfg_prdata = chars_r[3];
      REG_MASK_LENGTH:    cfg_prdata = 64'(len_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // handshake: a byte moves on unless it is last and the output is busy
  assign out_free  = !out_vld_r || out_tready;
  assign proc      = in_vld_r && (!end_r || out_free);
  assign in_tready = !in_vld_r || proc;

  // matching step
  assign step_cfg.chars = {chars_r[3], chars_r[2], chars_r[1], chars_r[0]};
  assign step_cfg.len   = len_r;

  wnm_step u_step (
    .cfg       (step_cfg),
    .act       (act_r),
    .name_byte (byte_r),
    .res       (step_res)
  );

  assign act_nxt = end_r ? POS_START : step_res.next_act;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      act_r     <= POS_START;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (proc) begin
        act_r <= act_nxt;
      end
      if (proc && end_r) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
    if (proc && end_r) begin
      matched_r <= step_res.matched;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, matched_r};

  // a verdict appears only after a last byte was matched
  a_out_from_last : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(proc && end_r))
    else $error("result raised without a last byte");

  // each name starts from the first mask position
  a_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (proc && end_r) |=> (act_r == POS_START))
    else $error("position vector not restarted after last byte");

  // a byte that ends no name never waits
  a_no_stall_mid : assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !end_r) |-> proc)
    else $error("non-last byte held in input register");

  // a blocked last byte keeps the output busy
  a_last_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && end_r && !proc) |-> (out_vld_r && !out_tready))
    else $error("last byte blocked with output free");

endmodule
